[rtl/core/qsu_pkg.sv]
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants for the quoted string unescape block.
// ----------------------------------------------------------------------------
package qsu_pkg;

  // Decoder state after the byte just taken
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,  // ordinary characters
    MODE_ESC   = 3'd1,  // backslash seen
    MODE_HEX0  = 3'd2,  // \x seen, no hex digit yet
    MODE_HEX1  = 3'd3,  // one hex digit held
    MODE_OCT   = 3'd4   // one or two octal digits held
  } qsu_mode_e;

  localparam int unsigned MaxBytes   = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerV    = 8'h76;
  localparam logic [7:0] CodeBell    = 8'h07;
  localparam logic [7:0] CodeBs      = 8'h08;
  localparam logic [7:0] CodeFf      = 8'h0C;
  localparam logic [7:0] CodeLf      = 8'h0A;
  localparam logic [7:0] CodeCr      = 8'h0D;
  localparam logic [7:0] CodeTab     = 8'h09;
  localparam logic [7:0] CodeVt      = 8'h0B;

  // Decoded bytes caused by one input byte
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;      // entry 0 goes out first
    logic [1:0]               count;      // 1 to 3 entries in use
    logic                     data_flag;  // 0 only for a bare end marker
    logic                     eos;        // last entry closes the literal
  } qsu_bundle_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

endpackage

[rtl/core/quoted_string_unescape.sv]
// ----------------------------------------------------------------------------
// quoted_string_unescape
// Decodes C-style escape sequences in the body of a quoted literal.
// ----------------------------------------------------------------------------
// One body byte is taken per cycle while the queue has room; each byte yields
// zero to three decoded bytes, and the output presents one decoded byte per
// cycle from a registered stage while the receiver is ready. Sustained rate is
// therefore one input byte per cycle while the input yields at most one byte
// each, and otherwise set by the single-byte output port: a byte that yields k
// results sends them out one at a time, with a four-entry queue of result
// groups absorbing bursts. The first result of a byte passes through the queue
// and then the output register. The last body byte always ends with a result
// marked tlast; tuser low marks a bare end marker that carries no byte.
module quoted_string_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tuser,   // [0] double_quoted
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] byte_valid
  output logic       m_axis_tlast    // end_of_string
);

  logic                 push_valid, push_ready;
  qsu_pkg::qsu_bundle_t push_bundle, head;
  logic                 head_valid, pop;

  qsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .char_i        (s_axis_tdata),
    .dq_i          (s_axis_tuser),
    .last_i        (s_axis_tlast),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_bundle_o (push_bundle)
  );

  qsu_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_valid_i  (push_valid),
    .push_ready_o  (push_ready),
    .push_bundle_i (push_bundle),
    .head_valid_o  (head_valid),
    .pop_i         (pop),
    .head_o        (head)
  );

  qsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_flag_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A request without data is only ever the end marker of a literal
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("bare result without end of string");

  // Decoder never hands over an empty group
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (push_bundle.count != 2'd0))
    else $error("empty bundle pushed");

  // Decoder never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("push into full queue");

  // A last input byte always produces a group closing the literal
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> (push_valid && push_bundle.eos))
    else $error("end of literal lost");
`endif

endmodule

[rtl/core/qsu_front.sv]
// ----------------------------------------------------------------------------
// qsu_front
// Takes one raw byte per cycle while the queue has room, tracks escape state
// and builds the bundle of decoded bytes that the byte causes.
// ----------------------------------------------------------------------------
module qsu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_i,
  input  logic                 dq_i,
  input  logic                 last_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output qsu_pkg::qsu_bundle_t push_bundle_o
);

  qsu_pkg::qsu_mode_e mode_q, mode_d, mode_step;
  logic [7:0]         val_q, val_d, val_step;
  logic [1:0]         cnt_q, cnt_d, cnt_step;
  logic               accept;
  logic [1:0]         cnt_inc;
  logic [7:0]         oct_val;
  logic [8:0]         letter;
  qsu_pkg::qsu_bundle_t bundle;

  function automatic qsu_pkg::qsu_bundle_t add_byte(qsu_pkg::qsu_bundle_t b,
                                                    logic [7:0] v);
    qsu_pkg::qsu_bundle_t r;
    r = b;
    if (r.count != 2'd3) begin
      r.bytes[r.count] = v;
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

  // Simple letter escapes of double-quoted mode: {hit, code}
  function automatic logic [8:0] letter_code(logic [7:0] c);
    logic [8:0] r;
    r = '0;
    case (c)
      qsu_pkg::ChLowerA: r = {1'b1, qsu_pkg::CodeBell};
      qsu_pkg::ChLowerB: r = {1'b1, qsu_pkg::CodeBs};
      qsu_pkg::ChLowerF: r = {1'b1, qsu_pkg::CodeFf};
      qsu_pkg::ChLowerN: r = {1'b1, qsu_pkg::CodeLf};
      qsu_pkg::ChLowerR: r = {1'b1, qsu_pkg::CodeCr};
      qsu_pkg::ChLowerT: r = {1'b1, qsu_pkg::CodeTab};
      qsu_pkg::ChLowerV: r = {1'b1, qsu_pkg::CodeVt};
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign cnt_inc    = cnt_q + 2'd1;
  assign oct_val    = {val_q[4:0], char_i[2:0]};
  assign letter     = letter_code(char_i);

  // Next state
  always_comb begin
    mode_step = mode_q;
    val_step  = val_q;
    cnt_step  = cnt_q;
    unique case (mode_q)
      qsu_pkg::MODE_ESC: begin
        mode_step = qsu_pkg::MODE_PLAIN;
        if (dq_i) begin
          if (char_i == qsu_pkg::ChLowerX) begin
            mode_step = qsu_pkg::MODE_HEX0;
          end else if (!letter[8] && qsu_pkg::is_oct(char_i)) begin
            mode_step = qsu_pkg::MODE_OCT;
            val_step  = {5'd0, char_i[2:0]};
            cnt_step  = 2'd1;
          end
        end
      end
      qsu_pkg::MODE_HEX0: begin
        if (qsu_pkg::is_hex(char_i)) begin
          mode_step = qsu_pkg::MODE_HEX1;
          val_step  = {4'd0, qsu_pkg::hex_val(char_i)};
        end else begin
          mode_step = (char_i == qsu_pkg::ChBackslash) ? qsu_pkg::MODE_ESC
                                                       : qsu_pkg::MODE_PLAIN;
        end
      end
      qsu_pkg::MODE_HEX1: begin
        if (qsu_pkg::is_hex(char_i)) begin
          mode_step = qsu_pkg::MODE_PLAIN;
        end else begin
          mode_step = (char_i == qsu_pkg::ChBackslash) ? qsu_pkg::MODE_ESC
                                                       : qsu_pkg::MODE_PLAIN;
        end
      end
      qsu_pkg::MODE_OCT: begin
        if (qsu_pkg::is_oct(char_i)) begin
          val_step = oct_val;
          cnt_step = cnt_inc;
          if (cnt_inc == 2'd3) begin
            mode_step = qsu_pkg::MODE_PLAIN;
          end
        end else begin
          mode_step = (char_i == qsu_pkg::ChBackslash) ? qsu_pkg::MODE_ESC
                                                       : qsu_pkg::MODE_PLAIN;
        end
      end
      default: begin
        mode_step = (char_i == qsu_pkg::ChBackslash) ? qsu_pkg::MODE_ESC
                                                     : qsu_pkg::MODE_PLAIN;
      end
    endcase

    mode_d = mode_step;
    val_d  = val_step;
    cnt_d  = cnt_step;
    if (last_i) begin
      mode_d = qsu_pkg::MODE_PLAIN;
      val_d  = '0;
      cnt_d  = '0;
    end
    if (mode_d == qsu_pkg::MODE_PLAIN || mode_d == qsu_pkg::MODE_ESC ||
        mode_d == qsu_pkg::MODE_HEX0) begin
      cnt_d = '0;
    end
    if (mode_d == qsu_pkg::MODE_PLAIN) begin
      val_d = '0;
    end
  end

  // Emitted bytes
  always_comb begin
    bundle           = '0;
    bundle.data_flag = 1'b1;
    bundle.eos       = last_i;
    unique case (mode_q)
      qsu_pkg::MODE_ESC: begin
        if (!dq_i) begin
          if (char_i != qsu_pkg::ChBackslash && char_i != qsu_pkg::ChQuote) begin
            bundle = add_byte(bundle, qsu_pkg::ChBackslash);
          end
          bundle = add_byte(bundle, char_i);
        end else if (letter[8]) begin
          bundle = add_byte(bundle, letter[7:0]);
        end else if (char_i != qsu_pkg::ChLowerX && !qsu_pkg::is_oct(char_i)) begin
          bundle = add_byte(bundle, char_i);
        end
      end
      qsu_pkg::MODE_HEX0: begin
        if (!qsu_pkg::is_hex(char_i)) begin
          bundle = add_byte(bundle, qsu_pkg::ChBackslash);
          bundle = add_byte(bundle, qsu_pkg::ChLowerX);
          if (char_i != qsu_pkg::ChBackslash) begin
            bundle = add_byte(bundle, char_i);
          end
        end
      end
      qsu_pkg::MODE_HEX1: begin
        if (qsu_pkg::is_hex(char_i)) begin
          bundle = add_byte(bundle, {val_q[3:0], qsu_pkg::hex_val(char_i)});
        end else begin
          bundle = add_byte(bundle, val_q);
          if (char_i != qsu_pkg::ChBackslash) begin
            bundle = add_byte(bundle, char_i);
          end
        end
      end
      qsu_pkg::MODE_OCT: begin
        if (qsu_pkg::is_oct(char_i)) begin
          if (cnt_inc == 2'd3) begin
            bundle = add_byte(bundle, oct_val);
          end
        end else begin
          bundle = add_byte(bundle, val_q);
          if (char_i != qsu_pkg::ChBackslash) begin
            bundle = add_byte(bundle, char_i);
          end
        end
      end
      default: begin
        if (char_i != qsu_pkg::ChBackslash) begin
          bundle = add_byte(bundle, char_i);
        end
      end
    endcase

    // Flush whatever is still pending at the end of the literal
    if (last_i) begin
      if (mode_step == qsu_pkg::MODE_HEX1 || mode_step == qsu_pkg::MODE_OCT) begin
        bundle = add_byte(bundle, val_step);
      end else if (mode_step == qsu_pkg::MODE_HEX0) begin
        bundle = add_byte(bundle, qsu_pkg::ChBackslash);
        bundle = add_byte(bundle, qsu_pkg::ChLowerX);
      end
      if (bundle.count == 2'd0) begin
        bundle.count     = 2'd1;
        bundle.data_flag = 1'b0;
      end
    end
  end

  assign push_valid_o  = accept && (bundle.count != 2'd0);
  assign push_bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qsu_pkg::MODE_PLAIN;
      val_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/qsu_queue.sv]
// ----------------------------------------------------------------------------
// qsu_queue
// Small FIFO of byte bundles between the decoder and the serializer.
// ----------------------------------------------------------------------------
module qsu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  qsu_pkg::qsu_bundle_t push_bundle_i,
  output logic                 head_valid_o,
  input  logic                 pop_i,
  output qsu_pkg::qsu_bundle_t head_o
);

  localparam int unsigned CntW = $clog2(qsu_pkg::QueueDepth + 1);

  qsu_pkg::qsu_bundle_t entries_q [qsu_pkg::QueueDepth];
  logic [qsu_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]               fill_q, fill_d;
  logic                          do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(qsu_pkg::QueueDepth));
  assign head_valid_o = (fill_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    fill_d = fill_q;
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + CntW'(1);
      2'b01:   fill_d = fill_q - CntW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_bundle_i;
    end
  end

endmodule

[rtl/core/qsu_back.sv]
// ----------------------------------------------------------------------------
// qsu_back
// Walks the head bundle one byte at a time into the output register.
// ----------------------------------------------------------------------------
module qsu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  qsu_pkg::qsu_bundle_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_flag_o,
  output logic                 out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       flag_q, last_q;
  logic       load, at_end;

  assign load   = head_valid_i && (!valid_q || out_ready_i);
  assign at_end = (idx_q == head_i.count - 2'd1);
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      flag_q <= head_i.data_flag;
      last_q <= head_i.eos && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_flag_o  = flag_q;
  assign out_last_o  = last_q;

endmodule
